// File: rtl/core/mch_pkg.sv
// Shared types, constants and the CORDIC angle table for the magnetometer
// calibration and heading block. No dependencies.
`timescale 1ns / 1ps

package mch_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int SCALE_FRAC_BITS = 14;
  localparam int SCALE_W         = SCALE_FRAC_BITS + 2;
  localparam int SPAN_W          = 16;
  localparam int SUM_W           = SPAN_W + 2;
  localparam int DEN_W           = SPAN_W + 2;
  localparam int NUM_W           = SUM_W + SCALE_FRAC_BITS;
  localparam int DCNT_W          = $clog2(NUM_W + 1);
  localparam int DIFF_W          = SAMPLE_W + 1;
  localparam int PROD_W          = SPAN_W + SCALE_W;
  localparam int SHIFT_W         = PROD_W - SCALE_FRAC_BITS;
  localparam int CORDIC_STEPS    = 16;
  localparam int STEP_W          = $clog2(CORDIC_STEPS + 1);
  localparam int IDX_W           = 5;
  localparam int CW              = 28;
  localparam int ZW              = 26;
  localparam int DEG_W           = 9;
  localparam int NUM_LANES       = 3;

  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC_BITS;
  localparam logic [SCALE_W-1:0] SCALE_TOP = '1;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_TRACK   = 2'd1;
  localparam logic [1:0] OP_COMMIT  = 2'd2;
  localparam logic [1:0] OP_MEASURE = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_SPAN = 2'd1;
  localparam logic [1:0] ST_SAT       = 2'd2;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;
  } mch_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] corrected_x;
    logic signed [SAMPLE_W-1:0] corrected_y;
    logic signed [SAMPLE_W-1:0] corrected_z;
    logic [DEG_W-1:0]           azimuth_deg;
    logic [1:0]                 status;
  } mch_out_t;

  typedef struct packed {
    logic clear;
    logic track;
    logic commit;
    logic measure;
  } lane_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic zero_span;
    logic sat;
  } lane_stat_t;

  // atan(2^-i) in 1/65536 degree, rounded
  function automatic logic [ZW-1:0] cordic_angle(input logic [IDX_W-1:0] i);
    logic [ZW-1:0] a;
    unique case (i)
      5'd0:  a = ZW'(2949120);
      5'd1:  a = ZW'(1740967);
      5'd2:  a = ZW'(919879);
      5'd3:  a = ZW'(466945);
      5'd4:  a = ZW'(234379);
      5'd5:  a = ZW'(117304);
      5'd6:  a = ZW'(58666);
      5'd7:  a = ZW'(29335);
      5'd8:  a = ZW'(14668);
      5'd9:  a = ZW'(7334);
      5'd10: a = ZW'(3667);
      5'd11: a = ZW'(1833);
      5'd12: a = ZW'(917);
      5'd13: a = ZW'(458);
      5'd14: a = ZW'(229);
      5'd15: a = ZW'(115);
      5'd16: a = ZW'(57);
      5'd17: a = ZW'(29);
      5'd18: a = ZW'(14);
      5'd19: a = ZW'(7);
      5'd20: a = ZW'(4);
      5'd21: a = ZW'(2);
      5'd22: a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/magnetometer_calibrate_heading.sv
// Start and track take no further steps; commit runs the 32-step scale divider
// (skipped when every span is zero); measure runs difference, multiply, 16 CORDIC
// steps and degree conversion. One request at a time; the next is taken once the
// result sits in the output register.
// Synchronous reset sets trackers to int16 extremes, offsets 0, scales one.
`timescale 1ns / 1ps

module magnetometer_calibrate_heading import mch_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  mch_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output mch_out_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_HEAD = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state;
  logic [1:0]       op;
  logic             acc;
  lane_cmd_t        cmd;
  logic signed [SAMPLE_W-1:0] samples [NUM_LANES];
  logic signed [SAMPLE_W-1:0] corr    [NUM_LANES];
  logic [SPAN_W-1:0] spans [NUM_LANES];
  lane_stat_t       stats [NUM_LANES];
  logic [SUM_W-1:0] span_sum;
  logic             hd_busy, hd_start;
  logic [DEG_W-1:0] deg;
  logic             any_busy, any_zero, any_sat;
  mch_out_t         result;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign cmd.clear   = acc && (in_data.opcode == OP_START);
  assign cmd.track   = acc && (in_data.opcode == OP_TRACK);
  assign cmd.commit  = acc && (in_data.opcode == OP_COMMIT);
  assign cmd.measure = acc && (in_data.opcode == OP_MEASURE);

  assign samples[0] = in_data.sample_x;
  assign samples[1] = in_data.sample_y;
  assign samples[2] = in_data.sample_z;
  assign span_sum = SUM_W'(spans[0]) + SUM_W'(spans[1]) + SUM_W'(spans[2]);

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    mch_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .sample   (samples[i]),
      .span_sum (span_sum),
      .span     (spans[i]),
      .corr     (corr[i]),
      .stat     (stats[i])
    );
  end

  assign any_busy = stats[0].div_busy | stats[1].div_busy | stats[2].div_busy;
  assign any_zero = stats[0].zero_span | stats[1].zero_span | stats[2].zero_span;
  assign any_sat  = stats[0].sat | stats[1].sat | stats[2].sat;
  assign hd_start = (state == S_MUL2);

  mch_heading u_heading (
    .clk   (clk),
    .rst   (rst),
    .start (hd_start),
    .x_in  (corr[0]),
    .y_in  (corr[1]),
    .busy  (hd_busy),
    .deg   (deg)
  );

  always_comb begin
    result = '0;
    unique case (op)
      OP_COMMIT:  result.status = any_zero ? ST_ZERO_SPAN : ST_OK;
      OP_MEASURE: begin
        result.corrected_x = corr[0];
        result.corrected_y = corr[1];
        result.corrected_z = corr[2];
        result.azimuth_deg = deg;
        result.status      = any_sat ? ST_SAT : ST_OK;
      end
      default: result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (acc) begin
          op <= in_data.opcode;
          priority if (in_data.opcode == OP_MEASURE) state <= S_MUL1;
          else if (in_data.opcode == OP_COMMIT) state <= S_DIV;
          else state <= S_DONE;
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_HEAD;
        S_DIV:  if (!any_busy) state <= S_DONE;
        S_HEAD: if (!hd_busy) state <= S_DONE;
        S_DONE: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          out_data  <= result;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    any_busy |-> (state == S_DIV))
    else $error("scale divider busy outside commit");
  a_head_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hd_busy)
    else $error("heading unit busy while idle");
  a_az_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.azimuth_deg < DEG_W'(360)) && (out_data.status != 2'd3))
    else $error("result out of range");
`endif

endmodule

// File: rtl/core/mch_lane.sv
// One axis lane: min/max tracking, offset and scale store, serial scale
// divider and the measure multiply with saturation. Uses mch_pkg.
`timescale 1ns / 1ps

module mch_lane import mch_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  lane_cmd_t                  cmd,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [SUM_W-1:0]           span_sum,
  output logic [SPAN_W-1:0]          span,
  output logic signed [SAMPLE_W-1:0] corr,
  output lane_stat_t                 stat
);

  logic signed [SAMPLE_W-1:0] min_seen, max_seen, axis_offset;
  logic [SCALE_W-1:0]         axis_scale;
  logic signed [DIFF_W-1:0]   span_s, pair_sum, pair_adj, diff, diff_in;
  logic [DEN_W-1:0]           den;
  logic [DEN_W-1:0]           rem;
  logic [DEN_W:0]             rem_s;
  logic [NUM_W-1:0]           num;
  logic                       ge;
  logic [DCNT_W-1:0]          dcnt;
  logic                       div_busy, zero_span;
  logic [SPAN_W-1:0]          abs_d;
  logic [PROD_W-1:0]          prod;
  logic                       neg;
  logic [SHIFT_W-1:0]         shifted;
  logic [SPAN_W:0]            mag;

  assign span_s = DIFF_W'(max_seen) - DIFF_W'(min_seen);
  assign span   = span_s[DIFF_W-1] ? '0 : span_s[SPAN_W-1:0];
  assign pair_sum = DIFF_W'(min_seen) + DIFF_W'(max_seen);
  // +1 on negatives so the halving truncates toward zero
  assign pair_adj = pair_sum + DIFF_W'(pair_sum[DIFF_W-1]);
  assign den      = DEN_W'({span, 1'b0}) + DEN_W'(span);

  assign rem_s = {rem, num[NUM_W-1]};
  assign ge    = rem_s >= (DEN_W+1)'(den);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      min_seen    <= 16'sh7fff;
      max_seen    <= 16'sh8000;
      axis_offset <= '0;
      axis_scale  <= SCALE_ONE;
      div_busy    <= 1'b0;
      zero_span   <= 1'b0;
      dcnt        <= '0;
    end else if (cmd.track) begin
      if (sample < min_seen) min_seen <= sample;
      if (sample > max_seen) max_seen <= sample;
    end else if (cmd.commit) begin
      axis_offset <= pair_adj[DIFF_W-1:1];
      zero_span   <= (span == '0);
      if (span == '0) axis_scale <= SCALE_ONE;
      else div_busy <= 1'b1;
      rem  <= '0;
      num  <= NUM_W'(span_sum) << SCALE_FRAC_BITS;
      dcnt <= '0;
    end else if (div_busy) begin
      rem  <= ge ? DEN_W'(rem_s - (DEN_W+1)'(den)) : rem_s[DEN_W-1:0];
      num  <= {num[NUM_W-2:0], ge};
      dcnt <= dcnt + 1'b1;
      if (dcnt == DCNT_W'(NUM_W - 1)) begin
        div_busy <= 1'b0;
        if (num[NUM_W-2:SCALE_W-1] != '0) axis_scale <= SCALE_TOP;
        else axis_scale <= {num[SCALE_W-2:0], ge};
      end
    end
  end

  // measure: difference at accept, product in the cycle after
  assign diff_in = DIFF_W'(sample) - DIFF_W'(axis_offset);

  always_ff @(posedge clk) begin
    if (cmd.measure) diff <= diff_in;
    neg  <= diff[DIFF_W-1];
    prod <= PROD_W'(abs_d) * PROD_W'(axis_scale);
  end

  assign abs_d   = diff[DIFF_W-1] ? SPAN_W'(-diff) : diff[SPAN_W-1:0];
  assign shifted = prod[PROD_W-1:SCALE_FRAC_BITS];
  assign mag     = (shifted > SHIFT_W'(65536)) ? 17'h10000 : shifted[SPAN_W:0];

  always_comb begin
    stat.div_busy  = div_busy;
    stat.zero_span = zero_span;
    stat.sat = 1'b0;
    if (neg) begin
      if (mag > 17'h08000) begin
        corr = 16'sh8000;
        stat.sat = 1'b1;
      end else begin
        corr = SAMPLE_W'(-mag);
      end
    end else begin
      if (mag > 17'h07fff) begin
        corr = 16'sh7fff;
        stat.sat = 1'b1;
      end else begin
        corr = mag[SAMPLE_W-1:0];
      end
    end
  end

endmodule

// File: rtl/core/mch_heading.sv
// Merging stage: iterative CORDIC vectoring on corrected x and y, one
// rotation per cycle, giving the heading in whole degrees. Uses mch_pkg.
`timescale 1ns / 1ps

module mch_heading import mch_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] x_in,
  input  logic signed [SAMPLE_W-1:0] y_in,
  output logic                       busy,
  output logic [DEG_W-1:0]           deg
);

  logic signed [CW-1:0] x, y, xs, ys, x0, y0;
  logic signed [ZW-1:0] z, a, base, ang;
  logic [STEP_W-1:0]    cnt;
  logic                 special;
  logic [DEG_W-1:0]     special_deg;
  logic signed [DEG_W+1:0] q, q_fix;

  assign x0  = CW'(x_in) <<< 8;
  assign y0  = CW'(y_in) <<< 8;
  assign xs  = x >>> cnt;
  assign ys  = y >>> cnt;
  assign ang = cordic_angle(IDX_W'(cnt));

  assign a = base + z;
  always_comb begin
    if (a[ZW-1]) q = -(DEG_W+2)'((-a) >>> 16);
    else q = (DEG_W+2)'(a >>> 16);
    q_fix = q;
    if (q[DEG_W+1]) q_fix = q + (DEG_W+2)'(360);
    else if (q >= (DEG_W+2)'(360)) q_fix = q - (DEG_W+2)'(360);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      z    <= '0;
      special <= (y_in == '0) || (x_in == '0);
      if (y_in == '0) special_deg <= x_in[SAMPLE_W-1] ? DEG_W'(180) : '0;
      else special_deg <= y_in[SAMPLE_W-1] ? DEG_W'(270) : DEG_W'(90);
      // fold left half plane by 180 degrees
      if (x_in[SAMPLE_W-1]) begin
        x    <= -x0;
        y    <= -y0;
        base <= y_in[SAMPLE_W-1] ? -ZW'(180 * 65536) : ZW'(180 * 65536);
      end else begin
        x    <= x0;
        y    <= y0;
        base <= '0;
      end
    end else if (busy) begin
      if (cnt == STEP_W'(CORDIC_STEPS)) begin
        busy <= 1'b0;
        deg  <= special ? special_deg : q_fix[DEG_W-1:0];
      end else begin
        cnt <= cnt + 1'b1;
        if (!y[CW-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + ang;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - ang;
        end
      end
    end
  end

endmodule
